// File: rtl/slb_pkg.sv
package slb_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam int S_W   = 24;
    localparam int Q_W   = 32;
    localparam int ENT_W = S_W + Q_W;
    localparam int SPAN_W = 6;
    localparam int N_W   = 2 * SPAN_W;
    localparam int DEN_W = 24;
    localparam int DIV_W = 64;

    localparam logic [8:0]  WIDTH_RST  = 9'd256;
    localparam logic [8:0]  HEIGHT_RST = 9'd256;
    localparam logic [15:0] K_RST      = 16'd22938;
    localparam logic [4:0]  HALF_RST   = 5'd6;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [7:0] BIN_LOW  = 8'd0;
    localparam logic [7:0] BIN_HIGH = 8'd255;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_K      = 2'd2,
        REG_HALF   = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_GEOM,
        ST_Q_READ,
        ST_Q_SUM,
        ST_Q_MUL,
        ST_Q_SUB,
        ST_Q_DIVM,
        ST_Q_DIVV,
        ST_Q_SQRT,
        ST_Q_FAC,
        ST_Q_FAC2,
        ST_Q_THR,
        ST_Q_OUT
    } state_t;

endpackage

// File: rtl/sauvola_local_binarizer.sv
// Channel   Handshake            Payload
// request   req_valid/req_stall  req_type, pixel, query_x, query_y
// response  rsp_valid/rsp_stall  bin_value, frame_ready
// config    APB (psel/penable)   paddr, pwdata, prdata
//
// Load transaction: accept, read row above, write integral entry.
// Query transaction: accept, geometry, 4 integral memory reads, window sums, multiply and
// subtract, the shared 2-bit-per-cycle divider (two passes, mean then variance), the square
// root, threshold factor and output.
// A query before a full frame goes straight to output. One transaction in flight at a time.
// Reset clears control state only; memories hold nothing valid until a frame loads.
// A finished result waits in the output register while the next request is taken; a query
// finishing behind a stalled result holds in its output state until that result is taken.
module sauvola_local_binarizer
    import slb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              req_type,
    input  logic [7:0]        pixel,
    input  logic [7:0]        query_x,
    input  logic [7:0]        query_y,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [7:0]        bin_value,
    output logic              frame_ready
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int GW0   = (XW > YW ? XW : YW) + 1;
    localparam int GW    = GW0 > 9 ? GW0 : 9;

    state_t state_reg, state_next;

    logic [8:0]  image_width_reg, image_height_reg;
    logic [15:0] k_scale_reg;
    logic [4:0]  window_half_reg;

    logic [GW-1:0] col_reg, row_reg;
    logic          frame_loaded_reg;
    logic [15:0]   rsum_reg;
    logic [23:0]   rsq_reg;
    logic [7:0]    pix_reg, qx_reg, qy_reg;
    logic          qready_reg;
    logic [4:0]    cnt_reg;

    logic [GW-1:0] xs_reg, ys_reg, x0_reg, x1_reg, y0_reg, y1_reg;
    logic [ENT_W-1:0] corner_reg [4];
    logic [S_W-1:0]   s_reg;
    logic [Q_W-1:0]   q_reg;
    logic [N_W-1:0]   n_reg;
    logic [43:0]      nq_reg;
    logic [47:0]      ss_reg, num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [15:0]      mean_reg;
    logic [31:0]      sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [31:0]      prod_reg;
    logic             neg_reg;
    logic [16:0]      factor_reg, thr_reg;

    logic       out_valid_reg;
    logic [7:0] bin_reg;
    logic       ready_out_reg;

    logic [ENT_W-1:0] int_mem [DEPTH];
    logic [7:0]       gray_mem [DEPTH];
    logic [ENT_W-1:0] int_rd;
    logic [7:0]       gray_rd;

    logic             int_re, int_we, gray_re, gray_we;
    logic [AW-1:0]    int_raddr, waddr, gray_raddr;
    logic [ENT_W-1:0] int_wdata;

    logic          cfg_wr, accept, out_free;
    logic [GW-1:0] act_w, act_h, iw, ih, rad;
    logic [3:0]    corner_ok;

    function automatic logic [AW-1:0] cell_addr(input logic [GW-1:0] x, input logic [GW-1:0] y);
        cell_addr = AW'(y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(x[XW-1:0]);
    endfunction

    function automatic logic [DEN_W:0] div_bit(input logic [DEN_W-1:0] rem, input logic din,
                                               input logic [DEN_W-1:0] d);
        logic [DEN_W:0] r1;
        logic           ge;
        r1 = {rem, din};
        ge = r1 >= {1'b0, d};
        if (ge)
        begin
            r1 = r1 - {1'b0, d};
        end
        div_bit = {ge, r1[DEN_W-1:0]};
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = req_valid && !req_stall;
    assign out_free = !out_valid_reg || !rsp_stall;

    assign iw = GW'(image_width_reg);
    assign ih = GW'(image_height_reg);
    assign act_w = (iw < GW'(2)) ? GW'(2) : ((iw > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : iw);
    assign act_h = (ih < GW'(2)) ? GW'(2) : ((ih > GW'(MAX_HEIGHT)) ? GW'(MAX_HEIGHT) : ih);
    assign rad = (window_half_reg == 5'd0) ? GW'(1) : GW'(window_half_reg);

    assign corner_ok[0] = 1'b1;
    assign corner_ok[1] = x0_reg != '0;
    assign corner_ok[2] = y0_reg != '0;
    assign corner_ok[3] = (x0_reg != '0) && (y0_reg != '0);

    always_comb
    begin
        case (cfg_reg_t'(paddr[3:2]))
            REG_WIDTH:  prdata = CFG_DW'(image_width_reg);
            REG_HEIGHT: prdata = CFG_DW'(image_height_reg);
            REG_K:      prdata = CFG_DW'(k_scale_reg);
            REG_HALF:   prdata = CFG_DW'(window_half_reg);
            default:    prdata = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type == REQ_QUERY)
                        state_next = frame_loaded_reg ? ST_Q_GEOM : ST_Q_OUT;
                    else
                        state_next = ST_LD_RD;
                end
            end
            ST_LD_RD:  state_next = ST_LD_WR;
            ST_LD_WR:  state_next = ST_IDLE;
            ST_Q_GEOM: state_next = ST_Q_READ;
            ST_Q_READ: state_next = (cnt_reg == 5'd4) ? ST_Q_SUM : ST_Q_READ;
            ST_Q_SUM:  state_next = ST_Q_MUL;
            ST_Q_MUL:  state_next = ST_Q_SUB;
            ST_Q_SUB:  state_next = ST_Q_DIVM;
            ST_Q_DIVM: state_next = (cnt_reg == 5'd31) ? ST_Q_DIVV : ST_Q_DIVM;
            ST_Q_DIVV: state_next = (cnt_reg == 5'd31) ? ST_Q_SQRT : ST_Q_DIVV;
            ST_Q_SQRT: state_next = (cnt_reg == 5'd15) ? ST_Q_FAC : ST_Q_SQRT;
            ST_Q_FAC:  state_next = ST_Q_FAC2;
            ST_Q_FAC2: state_next = ST_Q_THR;
            ST_Q_THR:  state_next = ST_Q_OUT;
            ST_Q_OUT:  state_next = out_free ? ST_IDLE : ST_Q_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb
    begin
        logic [15:0] rs_base, rs_new;
        logic [23:0] rq_base, rq_new;
        logic [S_W-1:0] above_s;
        logic [Q_W-1:0] above_q;
        req_stall  = state_reg != ST_IDLE;
        int_re     = 1'b0;
        int_raddr  = '0;
        gray_re    = 1'b0;
        gray_raddr = cell_addr(xs_reg, ys_reg);
        int_we     = 1'b0;
        gray_we    = 1'b0;
        waddr      = cell_addr(col_reg, row_reg);
        rs_base    = (col_reg == '0) ? 16'd0 : rsum_reg;
        rq_base    = (col_reg == '0) ? 24'd0 : rsq_reg;
        rs_new     = rs_base + 16'(pix_reg);
        rq_new     = rq_base + 24'(pix_reg) * 24'(pix_reg);
        above_s    = (row_reg == '0) ? '0 : int_rd[S_W-1:0];
        above_q    = (row_reg == '0) ? '0 : int_rd[ENT_W-1:S_W];
        int_wdata  = {above_q + Q_W'(rq_new), above_s + S_W'(rs_new)};
        unique case (state_reg)
            ST_LD_RD:
            begin
                int_re = row_reg != '0;
                int_raddr = (row_reg == '0) ? '0 : cell_addr(col_reg, row_reg - GW'(1));
            end
            ST_LD_WR:
            begin
                int_we  = 1'b1;
                gray_we = 1'b1;
            end
            ST_Q_READ:
            begin
                int_re  = !cnt_reg[2];
                gray_re = cnt_reg == 5'd0;
                if (corner_ok[cnt_reg[1:0]])
                begin
                    case (cnt_reg[1:0])
                        2'd0:    int_raddr = cell_addr(x1_reg, y1_reg);
                        2'd1:    int_raddr = cell_addr(x0_reg - GW'(1), y1_reg);
                        2'd2:    int_raddr = cell_addr(x1_reg, y0_reg - GW'(1));
                        default: int_raddr = cell_addr(x0_reg - GW'(1), y0_reg - GW'(1));
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (int_we)
            int_mem[waddr] <= int_wdata;
        if (int_re)
            int_rd <= int_mem[int_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (gray_we)
            gray_mem[waddr] <= pix_reg;
        if (gray_re)
            gray_rd <= gray_mem[gray_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            k_scale_reg      <= K_RST;
            window_half_reg  <= HALF_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            frame_loaded_reg <= 1'b0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (cfg_reg_t'(paddr[3:2]))
                    REG_WIDTH:
                    begin
                        image_width_reg  <= pwdata[8:0];
                        col_reg          <= '0;
                        row_reg          <= '0;
                        frame_loaded_reg <= 1'b0;
                    end
                    REG_HEIGHT:
                    begin
                        image_height_reg <= pwdata[8:0];
                        col_reg          <= '0;
                        row_reg          <= '0;
                        frame_loaded_reg <= 1'b0;
                    end
                    REG_K:    k_scale_reg     <= pwdata[15:0];
                    REG_HALF: window_half_reg <= pwdata[4:0];
                    default:
                    begin
                    end
                endcase
            end
            else if (accept && req_type == REQ_LOAD && frame_loaded_reg)
            begin
                col_reg          <= '0;
                row_reg          <= '0;
                frame_loaded_reg <= 1'b0;
            end
            else if (state_reg == ST_LD_WR)
            begin
                if (col_reg + GW'(1) >= act_w)
                begin
                    col_reg <= '0;
                    if (row_reg + GW'(1) >= act_h)
                    begin
                        row_reg          <= '0;
                        frame_loaded_reg <= 1'b1;
                    end
                    else
                        row_reg <= row_reg + GW'(1);
                end
                else
                    col_reg <= col_reg + GW'(1);
            end

            case (state_reg)
                ST_Q_GEOM, ST_Q_SUB: cnt_reg <= '0;
                ST_Q_READ, ST_Q_DIVM, ST_Q_DIVV, ST_Q_SQRT: cnt_reg <= cnt_reg + 5'd1;
                default:
                begin
                end
            endcase

            if (state_reg == ST_Q_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        logic [GW-1:0]    xs, ys, lastx, lasty;
        logic [SPAN_W-1:0] nx, ny;
        logic [DEN_W:0]   b1, b2;
        logic [DIV_W-1:0] q1, q2;
        logic [DEN_W-1:0] dv;
        logic [31:0]      t;
        logic [15:0]      sd;
        logic             hit;
        lastx = act_w - GW'(1);
        lasty = act_h - GW'(1);
        xs = (GW'(qx_reg) > lastx) ? lastx : GW'(qx_reg);
        ys = (GW'(qy_reg) > lasty) ? lasty : GW'(qy_reg);
        nx = SPAN_W'(x1_reg - x0_reg + GW'(1));
        ny = SPAN_W'(y1_reg - y0_reg + GW'(1));
        dv = (state_reg == ST_Q_DIVV) ? den_reg : DEN_W'(n_reg);
        b1 = div_bit(rem_reg, quo_reg[DIV_W-1], dv);
        q1 = {quo_reg[DIV_W-2:0], b1[DEN_W]};
        b2 = div_bit(b1[DEN_W-1:0], q1[DIV_W-1], dv);
        q2 = {q1[DIV_W-2:0], b2[DEN_W]};
        t  = sq_res_reg + sq_bit_reg;
        sd = sq_res_reg[15:0];
        hit = {1'b0, gray_rd, 8'd0} < thr_reg;

        if (accept)
        begin
            pix_reg    <= pixel;
            qx_reg     <= query_x;
            qy_reg     <= query_y;
            qready_reg <= frame_loaded_reg;
        end

        case (state_reg)
            ST_LD_WR:
            begin
                rsum_reg <= ((col_reg == '0) ? 16'd0 : rsum_reg) + 16'(pix_reg);
                rsq_reg  <= ((col_reg == '0) ? 24'd0 : rsq_reg) + 24'(pix_reg) * 24'(pix_reg);
            end
            ST_Q_GEOM:
            begin
                xs_reg <= xs;
                ys_reg <= ys;
                x0_reg <= (xs > rad) ? xs - rad : '0;
                y0_reg <= (ys > rad) ? ys - rad : '0;
                x1_reg <= (xs + rad < lastx) ? xs + rad : lastx;
                y1_reg <= (ys + rad < lasty) ? ys + rad : lasty;
            end
            ST_Q_READ:
            begin
                if (cnt_reg != 5'd0)
                    corner_reg[2'(cnt_reg - 5'd1)] <=
                        corner_ok[2'(cnt_reg - 5'd1)] ? int_rd : '0;
            end
            ST_Q_SUM:
            begin
                s_reg <= corner_reg[0][S_W-1:0] - corner_reg[1][S_W-1:0]
                       - corner_reg[2][S_W-1:0] + corner_reg[3][S_W-1:0];
                q_reg <= corner_reg[0][ENT_W-1:S_W] - corner_reg[1][ENT_W-1:S_W]
                       - corner_reg[2][ENT_W-1:S_W] + corner_reg[3][ENT_W-1:S_W];
                n_reg <= N_W'(nx) * N_W'(ny);
            end
            ST_Q_MUL:
            begin
                nq_reg <= 44'(n_reg) * 44'(q_reg);
                ss_reg <= 48'(s_reg) * 48'(s_reg);
            end
            ST_Q_SUB:
            begin
                num_reg <= (48'(nq_reg) >= ss_reg) ? 48'(nq_reg) - ss_reg : '0;
                den_reg <= DEN_W'(n_reg) * DEN_W'(n_reg - N_W'(1));
                quo_reg <= DIV_W'({s_reg, 8'd0});
                rem_reg <= '0;
            end
            ST_Q_DIVM:
            begin
                if (cnt_reg == 5'd31)
                begin
                    mean_reg <= q2[15:0];
                    quo_reg  <= {num_reg, 16'd0};
                    rem_reg  <= '0;
                end
                else
                begin
                    quo_reg <= q2;
                    rem_reg <= b2[DEN_W-1:0];
                end
            end
            ST_Q_DIVV:
            begin
                quo_reg <= q2;
                rem_reg <= b2[DEN_W-1:0];
                if (cnt_reg == 5'd31)
                begin
                    sq_v_reg   <= q2[31:0];
                    sq_res_reg <= '0;
                    sq_bit_reg <= 32'h4000_0000;
                end
            end
            ST_Q_SQRT:
            begin
                if (sq_v_reg >= t)
                begin
                    sq_v_reg   <= sq_v_reg - t;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_Q_FAC:
            begin
                neg_reg  <= !sd[15];
                prod_reg <= 32'(k_scale_reg) * (sd[15] ? 32'(sd[14:0]) : 32'(17'd32768 - 17'(sd)));
            end
            ST_Q_FAC2:
            begin
                if (neg_reg)
                    factor_reg <= 17'd65536 - 17'(({1'b0, prod_reg} + 33'd32767) >> 15);
                else
                    factor_reg <= 17'd65536 + 17'(prod_reg >> 15);
            end
            ST_Q_THR:
            begin
                thr_reg <= 17'((33'(mean_reg) * 33'(factor_reg)) >> 16);
            end
            ST_Q_OUT:
            begin
                if (out_free)
                begin
                    bin_reg       <= (qready_reg && !hit) ? BIN_HIGH : BIN_LOW;
                    ready_out_reg <= qready_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid   = out_valid_reg;
    assign bin_value   = bin_reg;
    assign frame_ready = ready_out_reg;

    a_load_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LD_WR |-> (col_reg < act_w && row_reg < act_h))
        else $error("load position outside active frame");

    a_frame_done_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_loaded_reg) |-> $past(state_reg) == ST_LD_WR)
        else $error("frame marked loaded without a load write");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_Q_SQRT |-> rem_reg < den_reg)
        else $error("variance divider remainder not below divisor");

    a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && state_reg != ST_Q_OUT) |=> !rsp_valid)
        else $error("response repeated after transaction");

endmodule

// File: sim/sauvola_local_binarizer_tb.sv
module sauvola_local_binarizer_tb;
    import slb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int IDLE_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] bin;
        logic       ready;
    } bin_result_t;

    class binarizer_model;
        bit [8:0]  width_reg;
        bit [8:0]  height_reg;
        bit [15:0] k_reg;
        bit [4:0]  half_reg;
        bit [7:0]  gray [CELLS];
        bit [23:0] sum_tab [CELLS];
        bit [31:0] sq_tab [CELLS];
        bit [15:0] row_sum;
        bit [23:0] row_sq;
        int        col;
        int        row;
        bit        loaded;
        bin_result_t expected_q[$];
        int        errors;

        function new();
            width_reg = WIDTH_RST;
            height_reg = HEIGHT_RST;
            k_reg = K_RST;
            half_reg = HALF_RST;
            row_sum = 0;
            row_sq = 0;
            col = 0;
            row = 0;
            loaded = 0;
            errors = 0;
        endfunction

        function int act_w();
            return width_reg < 2 ? 2 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
        endfunction

        function int act_h();
            return height_reg < 2 ? 2 :
                (height_reg > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : height_reg);
        endfunction

        function void write_reg(cfg_reg_t idx, bit [31:0] val);
            case (idx)
                REG_WIDTH, REG_HEIGHT:
                begin
                    if (idx == REG_WIDTH)
                        width_reg = val[8:0];
                    else
                        height_reg = val[8:0];
                    col = 0;
                    row = 0;
                    loaded = 0;
                end
                REG_K: k_reg = val[15:0];
                REG_HALF: half_reg = val[4:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function void load_pixel(bit [7:0] p);
            int c;
            bit [23:0] above_s;
            bit [31:0] above_q;
            above_s = 0;
            above_q = 0;
            if (loaded)
            begin
                loaded = 0;
                col = 0;
                row = 0;
            end
            if (col == 0)
            begin
                row_sum = 0;
                row_sq = 0;
            end
            c = row * DEF_MAX_WIDTH + col;
            gray[c] = p;
            row_sum = row_sum + p;
            row_sq = row_sq + p * p;
            if (row > 0)
            begin
                above_s = sum_tab[c - DEF_MAX_WIDTH];
                above_q = sq_tab[c - DEF_MAX_WIDTH];
            end
            sum_tab[c] = above_s + row_sum;
            sq_tab[c] = above_q + 32'(row_sq);
            col++;
            if (col >= act_w())
            begin
                col = 0;
                row++;
                if (row >= act_h())
                begin
                    row = 0;
                    loaded = 1;
                end
            end
        endfunction

        function bit [31:0] corner(bit sq, int x1, int y1);
            if (x1 == 0 || y1 == 0)
                return 0;
            return sq ? sq_tab[(y1 - 1) * DEF_MAX_WIDTH + x1 - 1]
                      : 32'(sum_tab[(y1 - 1) * DEF_MAX_WIDTH + x1 - 1]);
        endfunction

        function bit [7:0] classify(int x, int y);
            int w;
            int h;
            int r;
            int x0;
            int x1;
            int y0;
            int y1;
            bit [23:0] s;
            bit [31:0] q;
            longint unsigned n;
            longint unsigned mean;
            longint unsigned num;
            longint unsigned sd;
            longint unsigned factor;
            longint unsigned thr;
            w = act_w();
            h = act_h();
            r = half_reg < 1 ? 1 : half_reg;
            if (x >= w)
                x = w - 1;
            if (y >= h)
                y = h - 1;
            x0 = x > r ? x - r : 0;
            y0 = y > r ? y - r : 0;
            x1 = x + r < w - 1 ? x + r : w - 1;
            y1 = y + r < h - 1 ? y + r : h - 1;
            n = (x1 - x0 + 1) * (y1 - y0 + 1);
            s = 24'(corner(0, x1 + 1, y1 + 1) - corner(0, x0, y1 + 1)
                  - corner(0, x1 + 1, y0) + corner(0, x0, y0));
            q = corner(1, x1 + 1, y1 + 1) - corner(1, x0, y1 + 1)
              - corner(1, x1 + 1, y0) + corner(1, x0, y0);
            mean = (64'(s) * 256) / n;
            num = n * 64'(q);
            if (num >= 64'(s) * 64'(s))
                num = num - 64'(s) * 64'(s);
            else
                num = 0;
            sd = int_sqrt((num * 65536) / (n * (n - 1)));
            if (sd >= 32768)
                factor = 65536 + ((64'(k_reg) * (sd - 32768)) >> 15);
            else
                factor = 65536 - ((64'(k_reg) * (32768 - sd) + 32767) >> 15);
            thr = (mean * factor) >> 16;
            return (64'(gray[y * DEF_MAX_WIDTH + x]) * 256 < thr) ? BIN_LOW : BIN_HIGH;
        endfunction

        function void note_request(logic t, bit [7:0] p, bit [7:0] x, bit [7:0] y);
            bin_result_t e;
            if (t == REQ_LOAD)
                load_pixel(p);
            else
            begin
                e.ready = loaded;
                e.bin = loaded ? classify(x, y) : BIN_LOW;
                expected_q = {expected_q, e};
            end
        endfunction

        function void check_result(logic [7:0] bin, logic ready);
            bin_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result bin_value=%0d frame_ready=%0d",
                         $time, bin, ready);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (bin !== e.bin)
            begin
                $display("%0t: bin_value expected %0d actual %0d", $time, e.bin, bin);
                errors++;
            end
            if (ready !== e.ready)
            begin
                $display("%0t: frame_ready expected %0d actual %0d", $time, e.ready, ready);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;
    logic              req_valid;
    logic              req_stall;
    logic              req_type;
    logic [7:0]        pixel;
    logic [7:0]        query_x;
    logic [7:0]        query_y;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [7:0]        bin_value;
    logic              frame_ready;

    sauvola_local_binarizer DUT (.*);

    binarizer_model model = new();
    int  sent;
    int  burst_left;
    int  idle_cycles;
    int  stall_left;
    int  stall_pct;
    bit  rsp_fire;
    logic [7:0] rsp_bin;
    logic rsp_ready;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(negedge clk)
    begin
        rsp_fire <= rsp_valid && !rsp_stall;
        rsp_bin <= bin_value;
        rsp_ready <= frame_ready;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_fire)
            model.check_result(rsp_bin, rsp_ready);
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(10, 200);
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 90;
            endcase
        end
        stall_left--;
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, bit [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= CFG_AW'(4 * int'(idx));
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model.write_reg(idx, val);
    endtask

    task automatic send(logic t, bit [7:0] p, bit [7:0] x, bit [7:0] y);
        bit acc;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(2) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_type <= t;
        pixel <= p;
        query_x <= x;
        query_y <= y;
        forever
        begin
            @(negedge clk);
            acc = !req_stall;
            @(posedge clk);
            if (acc)
                break;
        end
        model.note_request(t, p, x, y);
        sent++;
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (model.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic setup(bit [8:0] w, bit [8:0] h, bit [15:0] k, bit [4:0] half);
        settle();
        write_reg(REG_WIDTH, 32'(w));
        write_reg(REG_HEIGHT, 32'(h));
        write_reg(REG_K, 32'(k));
        write_reg(REG_HALF, 32'(half));
    endtask

    function automatic bit [7:0] gen_pixel(int mode);
        case (mode)
            0: return 8'($urandom);
            1: return $urandom_range(1) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(200, 255));
            default: return 8'($urandom_range(90, 170));
        endcase
    endfunction

    task automatic load_frame(int count, int mode, int query_pct);
        for (int i = 0; i < count; i++)
        begin
            send(REQ_LOAD, gen_pixel(mode), 8'($urandom), 8'($urandom));
            if ($urandom_range(99) < query_pct)
                send(REQ_QUERY, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_queries(int count);
        int w;
        int h;
        w = model.act_w();
        h = model.act_h();
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(4) == 0)
                send(REQ_QUERY, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send(REQ_QUERY, 8'($urandom), 8'($urandom_range(0, w - 1)),
                     8'($urandom_range(0, h - 1)));
        end
    endtask

    initial
    begin
        bit [8:0] w;
        bit [8:0] h;
        bit [15:0] k;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        req_type = REQ_LOAD;
        pixel = '0;
        query_x = '0;
        query_y = '0;
        sent = 0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send(REQ_QUERY, 8'd0, 8'd0, 8'd0);
        setup(9'd2, 9'd1, K_RST, 5'd0);
        send(REQ_LOAD, 8'd0, 8'd0, 8'd0);
        send(REQ_LOAD, 8'd255, 8'd0, 8'd0);
        send(REQ_QUERY, 8'd0, 8'd1, 8'd1);
        send(REQ_LOAD, 8'd128, 8'd0, 8'd0);
        send(REQ_LOAD, 8'd255, 8'd0, 8'd0);
        send(REQ_QUERY, 8'd0, 8'd0, 8'd0);
        send(REQ_QUERY, 8'd0, 8'd1, 8'd1);
        send(REQ_QUERY, 8'd0, 8'd255, 8'd255);
        send(REQ_QUERY, 8'd0, 8'd0, 8'd255);
        send(REQ_QUERY, 8'd0, 8'd255, 8'd0);
        send(REQ_LOAD, 8'd77, 8'd0, 8'd0);
        send(REQ_QUERY, 8'd0, 8'd0, 8'd0);
        send(REQ_LOAD, 8'd255, 8'd0, 8'd0);
        send(REQ_LOAD, 8'd0, 8'd0, 8'd0);
        send(REQ_LOAD, 8'd200, 8'd0, 8'd0);
        send(REQ_QUERY, 8'd0, 8'd0, 8'd1);
        send(REQ_QUERY, 8'd0, 8'd1, 8'd0);

        setup(9'd256, 9'd2, 16'hFFFF, 5'd31);
        load_frame(512, 1, 0);
        run_queries(20);
        setup(9'd0, 9'd511, 16'd0, 5'd31);
        load_frame(512, 0, 0);
        run_queries(20);

        while (sent < 1400)
        begin
            w = $urandom_range(3) == 0 ? 9'($urandom) : 9'($urandom_range(2, 16));
            h = $urandom_range(3) == 0 ? 9'($urandom_range(0, 3)) : 9'($urandom_range(2, 16));
            if (w > 16 && h > 2)
                h = 9'($urandom_range(0, 2));
            case ($urandom_range(3))
                0: k = 16'd0;
                1: k = 16'hFFFF;
                default: k = 16'($urandom);
            endcase
            setup(w, h, k, 5'($urandom));
            load_frame(model.act_w() * model.act_h(), $urandom_range(2),
                       $urandom_range(1) * 10);
            run_queries($urandom_range(5, 25));
            if ($urandom_range(3) == 0)
            begin
                load_frame($urandom_range(1, 3), 0, 50);
                run_queries(2);
            end
        end

        settle();
        repeat (200) @(posedge clk);
        if (model.errors == 0 && model.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
